[hdl/planar_rigid_frame_transform_core_assert.svh]
// Assertion macros for the planar rigid frame transform core.
`ifndef PLANAR_RIGID_FRAME_TRANSFORM_CORE_ASSERT_SVH
`define PLANAR_RIGID_FRAME_TRANSFORM_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PRFT_ASSERT_IMP(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("prft: implication check failed");
`define PRFT_ASSERT_NXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("prft: next-cycle check failed");
`else
`define PRFT_ASSERT_IMP(label, clock, reset, ante, cons)
`define PRFT_ASSERT_NXT(label, clock, reset, ante, cons)
`endif

`endif

[hdl/prft_pkg.sv]
// Package: widths, quarter-wave sine ROM and helpers for the frame transform core.
package prft_pkg;

  localparam int POSITION_BITS    = 32;
  localparam int ANGLE_BITS       = 16;
  localparam int SINE_TABLE_DEPTH = 1024;

  localparam int OP_W      = 2;
  localparam int THRESH_W  = 15;
  localparam int SINE_W    = 15;
  localparam int COEF_W    = SINE_W + 2;
  localparam int FRAC_W    = ANGLE_BITS - 2;
  localparam int IDX_W     = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int IDX_PROD_W = FRAC_W + IDX_W;
  localparam int POS_EXT_W = POSITION_BITS + 1;
  localparam int PROD_W    = POS_EXT_W + COEF_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int RND_W     = SUM_W - SINE_W;
  localparam int FIN_W     = RND_W + 1;
  localparam int ROUND_Q15 = 1 << (SINE_W - 1);

  localparam int IN_BITS    = 4 * POSITION_BITS + 2 * ANGLE_BITS;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 2 * POSITION_BITS + ANGLE_BITS;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int IN_PY_LSB = POSITION_BITS;
  localparam int IN_PH_LSB = 2 * POSITION_BITS;
  localparam int IN_FX_LSB = 2 * POSITION_BITS + ANGLE_BITS;
  localparam int IN_FY_LSB = 3 * POSITION_BITS + ANGLE_BITS;
  localparam int IN_FA_LSB = 4 * POSITION_BITS + ANGLE_BITS;

  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(SINE_TABLE_DEPTH);

  localparam logic signed [FIN_W-1:0] SAT_HI =
    {{(FIN_W - POSITION_BITS + 1){1'b0}}, {(POSITION_BITS - 1){1'b1}}};
  localparam logic signed [FIN_W-1:0] SAT_LO = ~SAT_HI;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [SINE_W-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

  // sin(pi/2 * i / depth) in Q15 from a Q30 Taylor series
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] q;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      t    = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
      t2   = (t * t) >> 30;
      term = t;
      sum  = $signed(t);
      term = ((term * t2) >> 30) / 64'd6;   sum = sum - $signed(term);
      term = ((term * t2) >> 30) / 64'd20;  sum = sum + $signed(term);
      term = ((term * t2) >> 30) / 64'd42;  sum = sum - $signed(term);
      term = ((term * t2) >> 30) / 64'd72;  sum = sum + $signed(term);
      term = ((term * t2) >> 30) / 64'd110; sum = sum - $signed(term);
      term = ((term * t2) >> 30) / 64'd156; sum = sum + $signed(term);
      term = ((term * t2) >> 30) / 64'd210; sum = sum - $signed(term);
      if (sum < 0) begin
        sum = 0;
      end
      q = (sum + 64'sd16384) >>> 15;
      if (q > 64'sd32767) begin
        q = 64'sd32767;
      end
      rom[i] = q[SINE_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // ROM address for an angle, mirrored in odd quadrants
  function automatic logic [IDX_W-1:0] table_index(input logic [ANGLE_BITS-1:0] ang);
    logic [IDX_PROD_W-1:0] scaled;
    logic [IDX_W-1:0] idx;
    scaled = (IDX_PROD_W'(ang[FRAC_W-1:0]) * IDX_PROD_W'(SINE_TABLE_DEPTH)
              + (IDX_PROD_W'(1) << (FRAC_W - 1))) >> FRAC_W;
    idx = scaled[IDX_W-1:0];
    if (idx > IDX_MAX) begin
      idx = IDX_MAX;
    end
    if (ang[ANGLE_BITS-2]) begin
      idx = IDX_MAX - idx;
    end
    return idx;
  endfunction

  function automatic logic [POSITION_BITS-1:0] saturate_pos(input logic signed [FIN_W-1:0] v);
    logic [POSITION_BITS-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[POSITION_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[POSITION_BITS-1:0];
    end else begin
      r = v[POSITION_BITS-1:0];
    end
    return r;
  endfunction

endpackage

[hdl/planar_rigid_frame_transform_core.sv]
// Top level: SE(2) pose/point transform between a local frame and the world.
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  tuser: operation; tdata: point and frame pose
//   m_*       out  m_tvalid/m_tready  tdata: out_x, out_y, out_heading
//   cfg_*     in   cfg_wen            cfg_wdata: rotation_skip_threshold
//
// Four-register pipeline: input register, sine ROM read, products, result.
// One transaction per cycle while m_tready is high; m_tvalid rises after stages a, b and c.
// Each stage advances when the one after it is empty or moving, so bubbles fill
// while the output stalls. rst clears all stage valids and the threshold.

`include "planar_rigid_frame_transform_core_assert.svh"

module planar_rigid_frame_transform_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [31:0] point_x, [63:32] point_y, [79:64] point_heading,
  // [111:80] frame_x, [143:112] frame_y, [159:144] frame_angle
  input  logic [prft_pkg::IN_DATA_W-1:0]    s_tdata,
  // [1:0] operation
  input  logic [prft_pkg::OP_W-1:0]         s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [31:0] out_x, [63:32] out_y, [79:64] out_heading
  output logic [prft_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              cfg_wen,
  input  logic [prft_pkg::THRESH_W-1:0]     cfg_wdata
);

  import prft_pkg::*;

  logic [THRESH_W-1:0] rotation_skip_threshold;

  // stage a: input register
  logic                             va;
  logic [OP_W-1:0]                  op_a;
  logic signed [POSITION_BITS-1:0]  px_a, py_a, fx_a, fy_a;
  logic [ANGLE_BITS-1:0]            ph_a, fa_a;

  // stage b: ROM data
  logic                             vb;
  logic [SINE_W-1:0]                sin_mag_b, cos_mag_b;
  logic                             sin_neg_b, cos_neg_b, rot_b, world_b;
  logic signed [POS_EXT_W-1:0]      x_b, y_b;
  logic signed [POSITION_BITS-1:0]  fx_b, fy_b;
  logic [ANGLE_BITS-1:0]            hd_b;

  // stage c: products
  logic                             vc;
  logic signed [PROD_W-1:0]         p_xc_c, p_ys_c, p_xs_c, p_yc_c;
  logic                             world_c;
  logic signed [POSITION_BITS-1:0]  fx_c, fy_c;
  logic [ANGLE_BITS-1:0]            hd_c;

  // result register
  logic [POSITION_BITS-1:0]         out_x, out_y;
  logic [ANGLE_BITS-1:0]            out_heading;

  logic out_en, c_en, b_en, a_en;

  assign out_en   = !m_tvalid || m_tready;
  assign c_en     = !vc || out_en;
  assign b_en     = !vb || c_en;
  assign a_en     = !va || b_en;
  assign s_tready = a_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_skip_threshold <= '0;
    end else if (cfg_wen) begin
      rotation_skip_threshold <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va       <= 1'b0;
      vb       <= 1'b0;
      vc       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (a_en) begin
        va <= s_tvalid;
      end
      if (b_en) begin
        vb <= va;
      end
      if (c_en) begin
        vc <= vb;
      end
      if (out_en) begin
        m_tvalid <= vc;
      end
    end
  end

  // ---------------- stage a ----------------
  always_ff @(posedge clk) begin
    if (a_en && s_tvalid) begin
      op_a <= s_tuser;
      px_a <= s_tdata[POSITION_BITS-1:0];
      py_a <= s_tdata[IN_PY_LSB +: POSITION_BITS];
      ph_a <= s_tdata[IN_PH_LSB +: ANGLE_BITS];
      fx_a <= s_tdata[IN_FX_LSB +: POSITION_BITS];
      fy_a <= s_tdata[IN_FY_LSB +: POSITION_BITS];
      fa_a <= s_tdata[IN_FA_LSB +: ANGLE_BITS];
    end
  end

  logic                         world_a, pose_a, rot_a;
  logic [ANGLE_BITS-1:0]        mag_a, rot_ang_a, cos_ang_a, hd_a;
  logic signed [POS_EXT_W-1:0]  x_a, y_a;

  always_comb begin
    world_a   = !op_a[0];
    pose_a    = !op_a[1];
    mag_a     = fa_a[ANGLE_BITS-1] ? (~fa_a + ANGLE_BITS'(1)) : fa_a;
    rot_a     = !(pose_a && (32'(mag_a) < 32'(rotation_skip_threshold)));
    rot_ang_a = world_a ? fa_a : (~fa_a + ANGLE_BITS'(1));
    cos_ang_a = rot_ang_a + QUARTER_TURN;
    if (world_a) begin
      x_a = POS_EXT_W'(px_a);
      y_a = POS_EXT_W'(py_a);
    end else begin
      x_a = POS_EXT_W'(px_a) - POS_EXT_W'(fx_a);
      y_a = POS_EXT_W'(py_a) - POS_EXT_W'(fy_a);
    end
    if (!pose_a) begin
      hd_a = ph_a;
    end else if (world_a) begin
      hd_a = ph_a + fa_a;
    end else begin
      hd_a = ph_a - fa_a;
    end
  end

  // ---------------- stage b ----------------
  always_ff @(posedge clk) begin
    if (b_en && va) begin
      sin_mag_b <= SINE_ROM[table_index(rot_ang_a)];
      cos_mag_b <= SINE_ROM[table_index(cos_ang_a)];
      sin_neg_b <= rot_ang_a[ANGLE_BITS-1];
      cos_neg_b <= cos_ang_a[ANGLE_BITS-1];
      rot_b     <= rot_a;
      world_b   <= world_a;
      x_b       <= x_a;
      y_b       <= y_a;
      fx_b      <= fx_a;
      fy_b      <= fy_a;
      hd_b      <= hd_a;
    end
  end

  logic signed [COEF_W-1:0] sin_coef, cos_coef, sin_pos, cos_pos;

  always_comb begin
    sin_pos = $signed({2'b00, sin_mag_b});
    cos_pos = $signed({2'b00, cos_mag_b});
    if (rot_b) begin
      sin_coef = sin_neg_b ? -sin_pos : sin_pos;
      cos_coef = cos_neg_b ? -cos_pos : cos_pos;
    end else begin
      // unit rotation: cosine of exactly one, sine zero
      sin_coef = '0;
      cos_coef = COEF_W'(1) <<< SINE_W;
    end
  end

  // ---------------- stage c ----------------
  always_ff @(posedge clk) begin
    if (c_en && vb) begin
      p_xc_c  <= x_b * cos_coef;
      p_ys_c  <= y_b * sin_coef;
      p_xs_c  <= x_b * sin_coef;
      p_yc_c  <= y_b * cos_coef;
      world_c <= world_b;
      fx_c    <= fx_b;
      fy_c    <= fy_b;
      hd_c    <= hd_b;
    end
  end

  logic signed [SUM_W-1:0]          sum_x, sum_y, sh_x, sh_y;
  logic signed [RND_W-1:0]          rnd_x, rnd_y;
  logic signed [POSITION_BITS-1:0]  fx_add, fy_add;
  logic signed [FIN_W-1:0]          fin_x, fin_y;

  always_comb begin
    sum_x  = SUM_W'(p_xc_c) - SUM_W'(p_ys_c) + SUM_W'(ROUND_Q15);
    sum_y  = SUM_W'(p_xs_c) + SUM_W'(p_yc_c) + SUM_W'(ROUND_Q15);
    sh_x   = sum_x >>> SINE_W;
    sh_y   = sum_y >>> SINE_W;
    rnd_x  = sh_x[RND_W-1:0];
    rnd_y  = sh_y[RND_W-1:0];
    fx_add = world_c ? fx_c : '0;
    fy_add = world_c ? fy_c : '0;
    fin_x  = FIN_W'(rnd_x) + FIN_W'(fx_add);
    fin_y  = FIN_W'(rnd_y) + FIN_W'(fy_add);
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (out_en && vc) begin
      out_x       <= saturate_pos(fin_x);
      out_y       <= saturate_pos(fin_y);
      out_heading <= hd_c;
    end
  end

  assign m_tdata = OUT_DATA_W'({out_heading, out_y, out_x});

  // ---------------- assertions ----------------
  `PRFT_ASSERT_IMP(a_stall_means_full, clk, rst, !s_tready, va && vb && vc && m_tvalid)
  `PRFT_ASSERT_NXT(a_accept_lands, clk, rst, s_tvalid && s_tready, va)
  `PRFT_ASSERT_IMP(a_out_from_pipe, clk, rst, $rose(m_tvalid), $past(vc))

endmodule
